// ===== rtl/aes_block_cipher_defines.svh =====
// assertion macros for the aes block cipher
`ifndef AES_BLOCK_CIPHER_DEFINES_SVH
`define AES_BLOCK_CIPHER_DEFINES_SVH

// checked only outside reset
`define AESBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define AESBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/aesbc_pkg.sv =====
// ---------------------------------------------------------------------------
// aesbc_pkg
// Shared types, register indexes and byte-level transforms of the cipher.
// ---------------------------------------------------------------------------
package aesbc_pkg;

  localparam int ScheduleWords = 60;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] REG_KEY_LEN = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_0 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_1 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY_2 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_KEY_3 = 3'd4;

  localparam logic [1:0] KEY_LEN_128 = 2'd0;
  localparam logic [1:0] KEY_LEN_192 = 2'd1;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic valid;
    logic op;
  } pipe_ctl_t;

  typedef struct packed {
    logic active;
    logic last;
  } round_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
    8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
    8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
    8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
    8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
    8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
    8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
    8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
    8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
    8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
    8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
    8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
    8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
    8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
    8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
    8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
    8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
    8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
    8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
    8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
    8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
    8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
    8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
    8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
    8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
    8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
    8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
    8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
    8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
    8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6A, 8'hD5, 8'h30, 8'h36, 8'hA5, 8'h38,
    8'hBF, 8'h40, 8'hA3, 8'h9E, 8'h81, 8'hF3, 8'hD7, 8'hFB,
    8'h7C, 8'hE3, 8'h39, 8'h82, 8'h9B, 8'h2F, 8'hFF, 8'h87,
    8'h34, 8'h8E, 8'h43, 8'h44, 8'hC4, 8'hDE, 8'hE9, 8'hCB,
    8'h54, 8'h7B, 8'h94, 8'h32, 8'hA6, 8'hC2, 8'h23, 8'h3D,
    8'hEE, 8'h4C, 8'h95, 8'h0B, 8'h42, 8'hFA, 8'hC3, 8'h4E,
    8'h08, 8'h2E, 8'hA1, 8'h66, 8'h28, 8'hD9, 8'h24, 8'hB2,
    8'h76, 8'h5B, 8'hA2, 8'h49, 8'h6D, 8'h8B, 8'hD1, 8'h25,
    8'h72, 8'hF8, 8'hF6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hD4, 8'hA4, 8'h5C, 8'hCC, 8'h5D, 8'h65, 8'hB6, 8'h92,
    8'h6C, 8'h70, 8'h48, 8'h50, 8'hFD, 8'hED, 8'hB9, 8'hDA,
    8'h5E, 8'h15, 8'h46, 8'h57, 8'hA7, 8'h8D, 8'h9D, 8'h84,
    8'h90, 8'hD8, 8'hAB, 8'h00, 8'h8C, 8'hBC, 8'hD3, 8'h0A,
    8'hF7, 8'hE4, 8'h58, 8'h05, 8'hB8, 8'hB3, 8'h45, 8'h06,
    8'hD0, 8'h2C, 8'h1E, 8'h8F, 8'hCA, 8'h3F, 8'h0F, 8'h02,
    8'hC1, 8'hAF, 8'hBD, 8'h03, 8'h01, 8'h13, 8'h8A, 8'h6B,
    8'h3A, 8'h91, 8'h11, 8'h41, 8'h4F, 8'h67, 8'hDC, 8'hEA,
    8'h97, 8'hF2, 8'hCF, 8'hCE, 8'hF0, 8'hB4, 8'hE6, 8'h73,
    8'h96, 8'hAC, 8'h74, 8'h22, 8'hE7, 8'hAD, 8'h35, 8'h85,
    8'hE2, 8'hF9, 8'h37, 8'hE8, 8'h1C, 8'h75, 8'hDF, 8'h6E,
    8'h47, 8'hF1, 8'h1A, 8'h71, 8'h1D, 8'h29, 8'hC5, 8'h89,
    8'h6F, 8'hB7, 8'h62, 8'h0E, 8'hAA, 8'h18, 8'hBE, 8'h1B,
    8'hFC, 8'h56, 8'h3E, 8'h4B, 8'hC6, 8'hD2, 8'h79, 8'h20,
    8'h9A, 8'hDB, 8'hC0, 8'hFE, 8'h78, 8'hCD, 8'h5A, 8'hF4,
    8'h1F, 8'hDD, 8'hA8, 8'h33, 8'h88, 8'h07, 8'hC7, 8'h31,
    8'hB1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hEC, 8'h5F,
    8'h60, 8'h51, 8'h7F, 8'hA9, 8'h19, 8'hB5, 8'h4A, 8'h0D,
    8'h2D, 8'hE5, 8'h7A, 8'h9F, 8'h93, 8'hC9, 8'h9C, 8'hEF,
    8'hA0, 8'hE0, 8'h3B, 8'h4D, 8'hAE, 8'h2A, 8'hF5, 8'hB0,
    8'hC8, 8'hEB, 8'hBB, 8'h3C, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2B, 8'h04, 8'h7E, 8'hBA, 8'h77, 8'hD6, 8'h26,
    8'hE1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0C, 8'h7D
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte b of the state sits at bits 127-8b downto 120-8b
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    r = '0;
    for (int b = 0; b < 16; b++) begin
      r[127-8*b -: 8] = inv ? INV_SBOX[s[127-8*b -: 8]] : SBOX[s[127-8*b -: 8]];
    end
    sub_bytes = r;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    int src;
    r = s;
    for (int row = 1; row < 4; row++) begin
      for (int c = 0; c < 4; c++) begin
        src = inv ? ((c + 4 - row) % 4) : ((c + row) % 4);
        r[127-8*(row+4*c) -: 8] = s[127-8*(row+4*src) -: 8];
      end
    end
    shift_rows = r;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    logic [7:0] x, x2, x4, x8;
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] m1 [4];
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        x = s[127-8*(4*c+k) -: 8];
        x2 = xtime(x);
        x4 = xtime(x2);
        x8 = xtime(x4);
        m1[k] = x;
        m2[k] = x2;
        m3[k] = x2 ^ x;
        m9[k] = x8 ^ x;
        mb[k] = x8 ^ x2 ^ x;
        md[k] = x8 ^ x4 ^ x;
        me[k] = x8 ^ x4 ^ x2;
      end
      if (inv) begin
        r[127-8*(4*c+0) -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
        r[127-8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
        r[127-8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
        r[127-8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
      end else begin
        r[127-8*(4*c+0) -: 8] = m2[0] ^ m3[1] ^ m1[2] ^ m1[3];
        r[127-8*(4*c+1) -: 8] = m1[0] ^ m2[1] ^ m3[2] ^ m1[3];
        r[127-8*(4*c+2) -: 8] = m1[0] ^ m1[1] ^ m2[2] ^ m3[3];
        r[127-8*(4*c+3) -: 8] = m3[0] ^ m1[1] ^ m1[2] ^ m2[3];
      end
    end
    mix_columns = r;
  endfunction

  // key words for the size, shrunk while the schedule would not fit
  function automatic logic [3:0] eff_nk(input logic [1:0] kl, input int sw);
    logic [3:0] nk;
    if (kl == KEY_LEN_128) begin
      nk = 4'd4;
    end else if (kl == KEY_LEN_192) begin
      nk = 4'd6;
    end else begin
      nk = 4'd8;
    end
    if (nk == 4'd8 && sw < 60) begin
      nk = 4'd6;
    end
    if (nk == 4'd6 && sw < 52) begin
      nk = 4'd4;
    end
    eff_nk = nk;
  endfunction

endpackage

// ===== rtl/aesbc_key_sched.sv =====
// ---------------------------------------------------------------------------
// aesbc_key_sched
// Key registers and round-key expansion, one schedule word per cycle.
// ---------------------------------------------------------------------------
module aesbc_key_sched import aesbc_pkg::*; #(
  parameter int SchedWords = ScheduleWords
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic [31:0]         rk_o [SchedWords],
  output logic [3:0]          rounds_o,
  output logic                busy_o
);

  localparam int IdxW = $clog2(SchedWords);
  localparam int CntW = $clog2(SchedWords + 1);

  logic [1:0]    kl_q;
  logic [63:0]   key_q [4];
  logic          pend_q, run_q;
  logic [3:0]    nk_q, nr_q, nk_new;
  logic [CntW-1:0] n_q, total;
  logic [2:0]    j_q;
  logic [7:0]    rc_q;
  logic [31:0]   win_q [8];
  logic [31:0]   rk_q [SchedWords];
  logic [31:0]   word_in [8];
  logic [31:0]   win_load [8];
  logic [31:0]   far_w, tmp_w, new_w;
  logic          wr_hit, done_run;

  assign nk_new = eff_nk(kl_q, SchedWords);
  assign total = CntW'(4 * (32'(nk_q) + 7));
  assign done_run = (n_q == total);
  assign wr_hit = cfg_we_i && (cfg_index_i <= REG_KEY_3);

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      word_in[n] = n[0] ? key_q[n/2][31:0] : key_q[n/2][63:32];
    end
    // newest word first
    for (int j = 0; j < 8; j++) begin
      win_load[j] = '0;
      if (4'(j) < nk_new) begin
        win_load[j] = word_in[3'(nk_new - 4'd1 - 4'(j))];
      end
    end
  end

  always_comb begin
    case (nk_q)
      4'd4:    far_w = win_q[3];
      4'd6:    far_w = win_q[5];
      default: far_w = win_q[7];
    endcase
    tmp_w = win_q[0];
    if (j_q == 3'd0) begin
      tmp_w = sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rc_q, 24'h0};
    end else if (nk_q == 4'd8 && j_q == 3'd4) begin
      tmp_w = sub_word(win_q[0]);
    end
    new_w = far_w ^ tmp_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kl_q <= KEY_LEN_128;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      pend_q <= 1'b0;
      run_q <= 1'b0;
      nk_q <= 4'd4;
      nr_q <= 4'd10;
      n_q <= '0;
      j_q <= '0;
      rc_q <= 8'h01;
    end else begin
      if (pend_q) begin
        nk_q <= nk_new;
        nr_q <= nk_new + 4'd6;
        n_q <= CntW'(nk_new);
        j_q <= '0;
        rc_q <= 8'h01;
        run_q <= 1'b1;
      end else if (run_q) begin
        if (done_run) begin
          run_q <= 1'b0;
        end else begin
          n_q <= n_q + 1'b1;
          if (4'(j_q) == nk_q - 4'd1) begin
            j_q <= '0;
          end else begin
            j_q <= j_q + 3'd1;
          end
          if (j_q == 3'd0) rc_q <= xtime(rc_q);
        end
      end
      pend_q <= wr_hit;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_KEY_LEN: kl_q <= cfg_wdata_i[1:0];
          REG_KEY_0:   key_q[0] <= cfg_wdata_i;
          REG_KEY_1:   key_q[1] <= cfg_wdata_i;
          REG_KEY_2:   key_q[2] <= cfg_wdata_i;
          REG_KEY_3:   key_q[3] <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // sliding window of the last eight schedule words
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      for (int j = 0; j < 8; j++) win_q[j] <= win_load[j];
    end else if (run_q && !done_run) begin
      win_q[0] <= new_w;
      for (int j = 1; j < 8; j++) win_q[j] <= win_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      for (int n = 0; n < 8; n++) begin
        if (n < SchedWords && 4'(n) < nk_new) rk_q[n] <= word_in[n];
      end
    end else if (run_q && !done_run) begin
      rk_q[n_q[IdxW-1:0]] <= new_w;
    end
  end

  assign rk_o = rk_q;
  assign rounds_o = nr_q;
  assign busy_o = pend_q | run_q;

endmodule

// ===== rtl/aesbc_round_cell.sv =====
// ---------------------------------------------------------------------------
// aesbc_round_cell
// One cipher round, forward or inverse, registered; idle rounds pass through.
// ---------------------------------------------------------------------------
module aesbc_round_cell import aesbc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pipe_ctl_t    ctl_i,
  input  logic [127:0] data_i,
  input  round_ctl_t   rnd_i,
  input  logic [127:0] enc_key_i,
  input  logic [127:0] dec_key_i,
  output pipe_ctl_t    ctl_o,
  output logic [127:0] data_o
);

  pipe_ctl_t    ctl_q;
  logic [127:0] data_q, data_d;
  logic [127:0] e_sr, e_mc, d_sb, d_ak;

  always_comb begin
    e_sr = shift_rows(sub_bytes(data_i, 1'b0), 1'b0);
    e_mc = rnd_i.last ? e_sr : mix_columns(e_sr, 1'b0);
    d_sb = sub_bytes(shift_rows(data_i, 1'b1), 1'b1);
    d_ak = d_sb ^ dec_key_i;
    if (!rnd_i.active) begin
      data_d = data_i;
    end else if (ctl_i.op == OP_DECRYPT) begin
      data_d = rnd_i.last ? d_ak : mix_columns(d_ak, 1'b1);
    end else begin
      data_d = e_mc ^ enc_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign ctl_o = ctl_q;
  assign data_o = data_q;

endmodule

// ===== rtl/aes_block_cipher.sv =====
// path from start to done: the input register, then all Nr_max round cells;
// every block runs the full row of round cells, fewer rounds pass through.
// throughput: one block per cycle unless busy, set by the unrolled cell row.
// after reset the key registers are zero; each key register write re-expands
// the schedule one word per cycle, busy stays high meanwhile.
// results leave on done_o for one cycle and cannot be stalled.
// ---------------------------------------------------------------------------
// aes_block_cipher
// AES-128/192/256 block cipher with a fully unrolled round pipeline.
// ---------------------------------------------------------------------------
`include "aes_block_cipher_defines.svh"

module aes_block_cipher import aesbc_pkg::*; #(
  parameter int SchedWords = ScheduleWords
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                start,
  output logic                busy,
  input  logic                op_i,
  input  logic [63:0]         block_hi_i,
  input  logic [63:0]         block_lo_i,
  output logic                done_o,
  output logic [63:0]         result_hi_o,
  output logic [63:0]         result_lo_o
);

  localparam int MaxRounds = (SchedWords / 4 - 1 > 14) ? 14 : SchedWords / 4 - 1;

  logic [31:0]  rk [SchedWords];
  logic [3:0]   rounds;
  logic [127:0] rkey [MaxRounds+1];
  logic [127:0] dk_opt [MaxRounds+1][3];
  logic [127:0] dec_key [MaxRounds+1];
  pipe_ctl_t    ctl [MaxRounds+1];
  logic [127:0] data [MaxRounds+1];
  pipe_ctl_t    ctl0_q;
  logic [127:0] data0_q;
  logic         accept;

  aesbc_key_sched #(.SchedWords(SchedWords)) u_key_sched (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .rk_o     (rk),
    .rounds_o (rounds),
    .busy_o   (busy)
  );

  for (genvar r = 0; r <= MaxRounds; r++) begin : g_rkey
    assign rkey[r] = {rk[4*r], rk[4*r+1], rk[4*r+2], rk[4*r+3]};
  end

  // decryption key of cell i is round nr - i, for each possible nr
  for (genvar i = 0; i <= MaxRounds; i++) begin : g_dkey
    for (genvar g = 0; g < 3; g++) begin : g_nr
      localparam int Nr = 10 + 2 * g;
      if (Nr <= MaxRounds && Nr >= i) begin : g_ok
        assign dk_opt[i][g] = rkey[Nr - i];
      end else begin : g_none
        assign dk_opt[i][g] = '0;
      end
    end
    always_comb begin
      case (rounds)
        4'd12:   dec_key[i] = dk_opt[i][1];
        4'd14:   dec_key[i] = dk_opt[i][2];
        default: dec_key[i] = dk_opt[i][0];
      endcase
    end
  end

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else begin
      ctl0_q.valid <= accept;
      ctl0_q.op <= op_i;
    end
  end

  // initial key addition
  always_ff @(posedge clk_i) begin
    data0_q <= {block_hi_i, block_lo_i} ^ ((op_i == OP_DECRYPT) ? dec_key[0] : rkey[0]);
  end

  assign ctl[0] = ctl0_q;
  assign data[0] = data0_q;

  for (genvar i = 1; i <= MaxRounds; i++) begin : g_cell
    round_ctl_t rnd;
    assign rnd.active = (4'(i) <= rounds);
    assign rnd.last = (4'(i) == rounds);
    aesbc_round_cell u_cell (
      .clk_i,
      .rst_ni,
      .ctl_i     (ctl[i-1]),
      .data_i    (data[i-1]),
      .rnd_i     (rnd),
      .enc_key_i (rkey[i]),
      .dec_key_i (dec_key[i]),
      .ctl_o     (ctl[i]),
      .data_o    (data[i])
    );
  end

  assign done_o = ctl[MaxRounds].valid;
  assign result_hi_o = data[MaxRounds][127:64];
  assign result_lo_o = data[MaxRounds][63:0];

  `AESBC_ASSERT(a_write_busy, (cfg_we_i && cfg_index_i <= REG_KEY_3) |=> busy, "key write did not start expansion")
  `AESBC_ASSERT(a_rounds_ok, !busy |-> (rounds == 4'd10 || rounds == 4'd12 || rounds == 4'd14), "bad round count")
  `AESBC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !done_o, "result strobe right after reset")

endmodule
